### rtl/time_range_slice_scheduler_assert.svh
// Assertion macros for the time range slice scheduler
`ifndef TIME_RANGE_SLICE_SCHEDULER_ASSERT_SVH
`define TIME_RANGE_SLICE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TRSS_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trss assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define TRSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trss assertion failed");

`endif

### rtl/trss_pkg.sv
// Shared types and constants for the time range slice scheduler
package trss_pkg;

	localparam int DIV_W     = 64;
	localparam int CNT_W     = 7;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam int MAX_SLICE_COUNT_DEF = 64;

	localparam logic [31:0]      TARGET_SIZE_RESET = 32'd67108864;
	localparam logic [CNT_W-1:0] SLICE_LIMIT_RESET = 7'd8;

	// most negative time value
	localparam logic signed [63:0] TIME_MIN = 64'sh8000_0000_0000_0000;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_TARGET_SLICE_SIZE = 1'b0,
		REG_SLICE_LIMIT       = 1'b1
	} reg_idx_t;

	// divider request and response
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

### rtl/trss_if.sv
// Request and slice channels of the time range slice scheduler

interface trss_req_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] extent_low;
	logic signed [63:0] extent_high;
	logic               lower_bound_present;
	logic signed [63:0] lower_bound;
	logic               upper_bound_present;
	logic signed [63:0] upper_bound;
	logic        [63:0] file_bytes;

	modport source (
		output valid, extent_low, extent_high, lower_bound_present, lower_bound,
		output upper_bound_present, upper_bound, file_bytes,
		input  ready
	);
	modport sink (
		input  valid, extent_low, extent_high, lower_bound_present, lower_bound,
		input  upper_bound_present, upper_bound, file_bytes,
		output ready
	);
endinterface

interface trss_rsp_if;
	logic               valid;
	logic               ready;
	logic        [5:0]  slice_number;
	logic               start_present;
	logic signed [63:0] start_time;
	logic               end_present;
	logic signed [63:0] end_time;
	logic               last_slice;

	modport source (
		output valid, slice_number, start_present, start_time, end_present,
		output end_time, last_slice,
		input  ready
	);
	modport sink (
		input  valid, slice_number, start_present, start_time, end_present,
		input  end_time, last_slice,
		output ready
	);
endinterface

### rtl/trss_div.sv
// Restoring divider, one quotient bit per cycle
module trss_div (
	input  logic                clk,
	input  logic                arst_n,
	input  trss_pkg::div_req_t  req,
	output trss_pkg::div_rsp_t  rsp
);
	import trss_pkg::*;

	localparam int IW = $clog2(DIV_W);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dsr_q;
	logic [IW-1:0]    iter_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W+1:0] trial;

	// trial subtract of the divisor from the shifted partial remainder
	assign trial = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
			iter_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dsr_q  <= req.divisor;
				iter_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (trial[DIV_W+1]) begin
					rem_q <= {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
					quo_q <= {quo_q[DIV_W-2:0], 1'b0};
				end else begin
					rem_q <= trial[DIV_W-1:0];
					quo_q <= {quo_q[DIV_W-2:0], 1'b1};
				end
				iter_q <= iter_q + 1'b1;
				if (iter_q == IW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### rtl/time_range_slice_scheduler.sv
// Flow: a request that yields slices runs two divides in one shared bit-serial divider
// before its first slice, then one slice per cycle while the sink takes them.
// Not ready while a request is in work.
// Reset: arst_n asynchronous, active low; registers return to 67108864 and 8.
// Top level of the time range slice scheduler
module time_range_slice_scheduler #(
	parameter int MAX_SLICE_COUNT = trss_pkg::MAX_SLICE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	trss_req_if.sink                      req,
	trss_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [trss_pkg::APB_AW-1:0]   paddr,
	input  logic [trss_pkg::APB_DW-1:0]   pwdata,
	output logic [trss_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import trss_pkg::*;

	`include "time_range_slice_scheduler_assert.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SPAN,
		ST_DIV1_GO,
		ST_DIV1,
		ST_COUNT,
		ST_DIV2,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [31:0]        target_size_q;
	logic [CNT_W-1:0]   slice_limit_q;

	logic signed [63:0] ext_lo_q, ext_hi_q, lo_raw_q, hi_raw_q;
	logic               lo_has_q, hi_has_q;
	logic [63:0]        bytes_q;
	logic signed [63:0] lo_q, hi_q;
	logic [63:0]        span_q, step_q, bound_q;
	logic [CNT_W-1:0]   count_q, k_q;

	logic               rsp_valid_q;
	logic [5:0]         slice_number_q;
	logic               start_present_q, end_present_q, last_slice_q;
	logic signed [63:0] start_time_q, end_time_q;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// configuration write and read
	logic     cfg_wr;
	reg_idx_t cfg_idx;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	always_comb begin
		unique case (cfg_idx)
			REG_TARGET_SLICE_SIZE: prdata = target_size_q;
			REG_SLICE_LIMIT:       prdata = {{(APB_DW-CNT_W){1'b0}}, slice_limit_q};
			default:               prdata = '0;
		endcase
	end

	// clamp range by filters
	logic signed [63:0] ub_m1, lo_n, hi_n;
	logic               abort_n;
	assign ub_m1   = hi_raw_q - 64'sd1;
	assign lo_n    = (lo_has_q && (lo_raw_q > ext_lo_q)) ? lo_raw_q : ext_lo_q;
	assign hi_n    = (hi_has_q && (ub_m1 < ext_hi_q)) ? ub_m1 : ext_hi_q;
	assign abort_n = (target_size_q == 32'd0) || (slice_limit_q == '0) ||
	                 (hi_has_q && (hi_raw_q == TIME_MIN));

	// slice count: quotient capped by limit and by span
	logic [CNT_W-1:0] limit_eff, cap_q, count_n;
	assign limit_eff = (slice_limit_q > CNT_W'(MAX_SLICE_COUNT)) ?
	                   CNT_W'(MAX_SLICE_COUNT) : slice_limit_q;
	assign cap_q     = (div_rsp.quotient < {{(DIV_W-CNT_W){1'b0}}, limit_eff}) ?
	                   div_rsp.quotient[CNT_W-1:0] : limit_eff;
	assign count_n   = (span_q < {{(64-CNT_W){1'b0}}, cap_q}) ? span_q[CNT_W-1:0] : cap_q;

	// divider requests: file size over target, then span over count
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = bytes_q;
		div_req.divisor  = {32'd0, target_size_q};
		if (state_q == ST_DIV1_GO && span_q != 64'd0) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_COUNT) begin
			div_req.start    = (count_n >= CNT_W'(2));
			div_req.dividend = span_q;
			div_req.divisor  = {{(DIV_W-CNT_W){1'b0}}, count_n};
		end
	end

	trss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// slice emission
	logic        load;
	logic        last_n;
	logic [63:0] next_bound;
	assign load       = (state_q == ST_EMIT) && (!rsp_valid_q || rsp.ready);
	assign last_n     = (k_q + CNT_W'(1)) == count_q;
	assign next_bound = bound_q + step_q;

	// sequencer, request capture and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			target_size_q   <= TARGET_SIZE_RESET;
			slice_limit_q   <= SLICE_LIMIT_RESET;
			ext_lo_q        <= '0;
			ext_hi_q        <= '0;
			lo_raw_q        <= '0;
			hi_raw_q        <= '0;
			lo_has_q        <= 1'b0;
			hi_has_q        <= 1'b0;
			bytes_q         <= '0;
			lo_q            <= '0;
			hi_q            <= '0;
			span_q          <= '0;
			step_q          <= '0;
			bound_q         <= '0;
			count_q         <= '0;
			k_q             <= '0;
			rsp_valid_q     <= 1'b0;
			slice_number_q  <= '0;
			start_present_q <= 1'b0;
			end_present_q   <= 1'b0;
			last_slice_q    <= 1'b0;
			start_time_q    <= '0;
			end_time_q      <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_TARGET_SLICE_SIZE: target_size_q <= pwdata;
					REG_SLICE_LIMIT:       slice_limit_q <= pwdata[CNT_W-1:0];
					default: ;
				endcase
			end

			// output valid: set on a new slice, cleared once the sink takes it
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						ext_lo_q <= req.extent_low;
						ext_hi_q <= req.extent_high;
						lo_has_q <= req.lower_bound_present;
						lo_raw_q <= req.lower_bound;
						hi_has_q <= req.upper_bound_present;
						hi_raw_q <= req.upper_bound;
						bytes_q  <= req.file_bytes;
						state_q  <= ST_PREP;
					end
				end
				ST_PREP: begin
					lo_q    <= lo_n;
					hi_q    <= hi_n;
					state_q <= abort_n ? ST_IDLE : ST_SPAN;
				end
				ST_SPAN: begin
					span_q  <= 64'(hi_q - lo_q) + 64'd1;
					state_q <= (lo_q > hi_q) ? ST_IDLE : ST_DIV1_GO;
				end
				ST_DIV1_GO: begin
					// full 2^64 span wraps to zero
					state_q <= (span_q == 64'd0) ? ST_IDLE : ST_DIV1;
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					count_q <= count_n;
					state_q <= (count_n >= CNT_W'(2)) ? ST_DIV2 : ST_IDLE;
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						step_q  <= div_rsp.quotient;
						bound_q <= lo_q;
						k_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						slice_number_q  <= k_q[5:0];
						last_slice_q    <= last_n;
						if (k_q == '0) begin
							start_present_q <= lo_has_q;
							start_time_q    <= lo_has_q ? lo_raw_q : 64'sd0;
						end else begin
							start_present_q <= 1'b1;
							start_time_q    <= bound_q;
						end
						if (last_n) begin
							end_present_q <= hi_has_q;
							end_time_q    <= hi_has_q ? hi_raw_q : 64'sd0;
							state_q       <= ST_IDLE;
						end else begin
							end_present_q <= 1'b1;
							end_time_q    <= next_bound;
						end
						bound_q <= next_bound;
						k_q     <= k_q + CNT_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.slice_number  = slice_number_q;
	assign rsp.start_present = start_present_q;
	assign rsp.start_time    = start_time_q;
	assign rsp.end_present   = end_present_q;
	assign rsp.end_time      = end_time_q;
	assign rsp.last_slice    = last_slice_q;

	// checks
	`TRSS_ASSERT(a_div_start_free, div_req.start, !div_rsp.busy)
	`TRSS_ASSERT(a_emit_in_count, state_q == ST_EMIT, (count_q >= CNT_W'(2)) && (k_q < count_q))
	`TRSS_ASSERT_NEXT(a_accept_to_prep, req.valid && req.ready, state_q == ST_PREP)

endmodule
